// ===== rtl/core/gmd_pkg.sv =====
// shared types, constants and widths of the grid min-distance keypoint filter
`timescale 1ns / 1ps
`default_nettype none
package gmd_pkg;

  localparam int GRID_COLS_MAX = 64;
  localparam int GRID_ROWS_MAX = 64;
  localparam int COL_W = (GRID_COLS_MAX > 1) ? $clog2(GRID_COLS_MAX) : 1;
  localparam int ROW_W = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;

  localparam int COORD_W = 16;
  localparam int DIM_W   = 13;
  localparam int CELL_W  = 8;
  localparam int ID_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(480);
  localparam logic [CELL_W-1:0] CELL_RESET   = CELL_W'(10);

  // iterative divider: four lanes share one divisor
  localparam int DIV_LANES  = 4;
  localparam int LANE_X     = 0;
  localparam int LANE_Y     = 1;
  localparam int LANE_W     = 2;
  localparam int LANE_H     = 3;
  localparam int QUOT_W     = DIM_W;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_KEY   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CELL_PIXELS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_PROBE  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } entry_t;

  typedef logic [DIV_LANES-1:0][QUOT_W-1:0] lanes_t;

endpackage
`default_nettype wire

// ===== rtl/core/gmd_div.sv =====
// four-lane restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module gmd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [gmd_pkg::CELL_W-1:0]  divisor,
  input  wire gmd_pkg::lanes_t             dividend,
  output logic                             done,
  output gmd_pkg::lanes_t                  quotient
);

  logic [gmd_pkg::CELL_W-1:0]                               dsr;
  gmd_pkg::lanes_t                                          quo;
  gmd_pkg::lanes_t                                          quo_next;
  logic [gmd_pkg::DIV_LANES-1:0][gmd_pkg::CELL_W-1:0]       rem;
  logic [gmd_pkg::DIV_LANES-1:0][gmd_pkg::CELL_W-1:0]       rem_next;
  logic [gmd_pkg::DIV_LANES-1:0][gmd_pkg::CELL_W:0]         rem_sh;
  logic [gmd_pkg::DIV_LANES-1:0]                            fits;
  logic [gmd_pkg::STEP_CNT_W-1:0]                           count;

  always_comb begin
    for (int i = 0; i < gmd_pkg::DIV_LANES; i++) begin
      rem_sh[i]   = {rem[i], quo[i][gmd_pkg::QUOT_W-1]};
      fits[i]     = rem_sh[i] >= {1'b0, dsr};
      rem_next[i] = fits[i] ? gmd_pkg::CELL_W'(rem_sh[i] - {1'b0, dsr})
                            : rem_sh[i][gmd_pkg::CELL_W-1:0];
      quo_next[i] = {quo[i][gmd_pkg::QUOT_W-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dsr   <= divisor;
        quo   <= dividend;
        rem   <= '0;
        count <= gmd_pkg::STEP_CNT_W'(gmd_pkg::DIV_STEPS);
      end else if (count != '0) begin
        rem   <= rem_next;
        quo   <= quo_next;
        count <= count - gmd_pkg::STEP_CNT_W'(1);
        done  <= (count == gmd_pkg::STEP_CNT_W'(1));
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// ===== rtl/core/gmd_front.sv =====
// front end: accepts beats, range checks, divides to a grid cell, classifies
`timescale 1ns / 1ps
`default_nettype none
module gmd_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               command,
  input  wire logic signed [gmd_pkg::COORD_W-1:0] key_x,
  input  wire logic signed [gmd_pkg::COORD_W-1:0] key_y,
  input  wire logic [gmd_pkg::DIM_W-1:0]          image_width,
  input  wire logic [gmd_pkg::DIM_W-1:0]          image_height,
  input  wire logic [gmd_pkg::CELL_W-1:0]         cell_pixels,
  output logic                                    push,
  output gmd_pkg::entry_t                         entry,
  input  wire logic                               full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PUSH
  } state_t;

  state_t                       state;
  logic                         in_range;
  logic                         hit;
  logic                         div_start;
  logic                         div_done;
  logic [gmd_pkg::CELL_W-1:0]   divisor;
  gmd_pkg::lanes_t              dividend;
  gmd_pkg::lanes_t              quot;

  assign in_ready = (state == ST_IDLE);

  assign in_range = !key_x[gmd_pkg::COORD_W-1] && !key_y[gmd_pkg::COORD_W-1] &&
    ({{(gmd_pkg::COORD_W-gmd_pkg::DIM_W){1'b0}}, image_width} > $unsigned(key_x)) &&
    ({{(gmd_pkg::COORD_W-gmd_pkg::DIM_W){1'b0}}, image_height} > $unsigned(key_y));

  assign div_start = in_valid && in_ready &&
                     (gmd_pkg::cmd_t'(command) == gmd_pkg::CMD_KEY) && in_range;

  assign divisor = (cell_pixels == '0) ? gmd_pkg::CELL_W'(1) : cell_pixels;

  always_comb begin
    dividend                  = '0;
    dividend[gmd_pkg::LANE_X] = key_x[gmd_pkg::DIM_W-1:0];
    dividend[gmd_pkg::LANE_Y] = key_y[gmd_pkg::DIM_W-1:0];
    dividend[gmd_pkg::LANE_W] = image_width;
    dividend[gmd_pkg::LANE_H] = image_height;
  end

  gmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor),
    .dividend (dividend),
    .done     (div_done),
    .quotient (quot)
  );

  assign hit = (quot[gmd_pkg::LANE_X] < quot[gmd_pkg::LANE_W]) &&
               (quot[gmd_pkg::LANE_Y] < quot[gmd_pkg::LANE_H]) &&
               (quot[gmd_pkg::LANE_X] < gmd_pkg::QUOT_W'(gmd_pkg::GRID_COLS_MAX)) &&
               (quot[gmd_pkg::LANE_Y] < gmd_pkg::QUOT_W'(gmd_pkg::GRID_ROWS_MAX));

  assign push = (state == ST_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            entry.row <= '0;
            entry.col <= '0;
            if (gmd_pkg::cmd_t'(command) == gmd_pkg::CMD_FRAME) begin
              entry.kind <= gmd_pkg::KIND_FRAME;
              state      <= ST_PUSH;
            end else if (!in_range) begin
              entry.kind <= gmd_pkg::KIND_REJECT;
              state      <= ST_PUSH;
            end else begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            entry.kind <= hit ? gmd_pkg::KIND_PROBE : gmd_pkg::KIND_REJECT;
            entry.row  <= quot[gmd_pkg::LANE_Y][gmd_pkg::ROW_W-1:0];
            entry.col  <= quot[gmd_pkg::LANE_X][gmd_pkg::COL_W-1:0];
            state      <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside the divide state");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/gmd_queue.sv =====
// short queue of classified entries between front and back
`timescale 1ns / 1ps
`default_nettype none
module gmd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire gmd_pkg::entry_t  din,
  output logic                  full,
  input  wire logic             pop,
  output gmd_pkg::entry_t       head,
  output logic                  empty
);

  gmd_pkg::entry_t              slots [gmd_pkg::QDEPTH];
  logic [gmd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [gmd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [gmd_pkg::QPTR_W:0]     count;

  assign full  = (count == (gmd_pkg::QPTR_W+1)'(gmd_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gmd_pkg::QPTR_W'(gmd_pkg::QDEPTH - 1)) ? '0
                : wr_ptr + gmd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gmd_pkg::QPTR_W'(gmd_pkg::QDEPTH - 1)) ? '0
                : rd_ptr + gmd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (gmd_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (gmd_pkg::QPTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gmd_back.sv =====
// back end: occupancy read-modify-write, id counter and result register
`timescale 1ns / 1ps
`default_nettype none
module gmd_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire gmd_pkg::entry_t           head,
  input  wire logic                      empty,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           accepted,
  output logic [gmd_pkg::ID_W-1:0]       feature_id
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t                                  state;
  logic [gmd_pkg::GRID_COLS_MAX-1:0]       mem [gmd_pkg::GRID_ROWS_MAX];
  logic [gmd_pkg::GRID_COLS_MAX-1:0]       rd_data;
  logic [gmd_pkg::GRID_COLS_MAX-1:0]       row_bits;
  logic [gmd_pkg::GRID_COLS_MAX-1:0]       wr_data;
  logic [gmd_pkg::GRID_ROWS_MAX-1:0]       row_valid;
  logic [gmd_pkg::ROW_W-1:0]               look_row;
  logic [gmd_pkg::COL_W-1:0]               look_col;
  logic [gmd_pkg::ID_W-1:0]                id_counter;
  logic [gmd_pkg::ID_W-1:0]                id_next;
  logic                                    occupied;
  logic                                    mem_we;

  assign pop = (state == ST_IDLE) && !empty && (!out_valid || out_ready);

  // a row not written since the last frame start reads as empty
  assign row_bits = row_valid[look_row] ? rd_data : '0;
  assign occupied = row_bits[look_col];
  assign wr_data  = row_bits | (gmd_pkg::GRID_COLS_MAX'(1) << look_col);
  assign mem_we   = (state == ST_LOOK) && !occupied;
  assign id_next  = id_counter + gmd_pkg::ID_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[look_row] <= wr_data;
    end
    rd_data <= mem[head.row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row_valid  <= '0;
      id_counter <= '0;
      out_valid  <= 1'b0;
      accepted   <= 1'b0;
      feature_id <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.kind)
              gmd_pkg::KIND_FRAME: begin
                row_valid  <= '0;
                out_valid  <= 1'b1;
                accepted   <= 1'b0;
                feature_id <= '0;
              end
              gmd_pkg::KIND_PROBE: begin
                look_row <= head.row;
                look_col <= head.col;
                state    <= ST_LOOK;
              end
              default: begin
                out_valid  <= 1'b1;
                accepted   <= 1'b0;
                feature_id <= '0;
              end
            endcase
          end
        end
        ST_LOOK: begin
          out_valid <= 1'b1;
          if (occupied) begin
            accepted   <= 1'b0;
            feature_id <= '0;
          end else begin
            row_valid[look_row] <= 1'b1;
            id_counter          <= id_next;
            accepted            <= 1'b1;
            feature_id          <= id_next;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_look_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |=> (state == ST_IDLE) && out_valid)
    else $error("occupancy lookup did not produce a result beat");

  a_kept_id_matches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (feature_id == id_counter))
    else $error("kept keypoint id differs from id counter");

  a_rejected_id_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (feature_id == '0))
    else $error("rejected beat carries a nonzero id");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/grid_min_distance_keypoint_filter_core.sv =====
// top level of the grid min-distance keypoint filter with its config registers
//
//   channel   signals                               direction
//   in        in_valid in_ready command key_x key_y  in
//   out       out_valid out_ready accepted feature_id out
//   cfg       cfg_write cfg_index cfg_data           in
//
// a keypoint inside the image goes through the 13-step divider in the front end,
// which takes no new beat until that keypoint's entry is pushed into the queue
// frame starts and out-of-image keypoints skip the divider and go straight to the queue
// the back end reads the occupancy row as it pops an entry and writes it back in its look state
// rst is synchronous; the grid reads empty right after reset, no clearing pass
// a stalled result beat holds the back end; the queue keeps the front end going until it fills
`timescale 1ns / 1ps
`default_nettype none
module grid_min_distance_keypoint_filter_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               command,
  input  wire logic signed [gmd_pkg::COORD_W-1:0] key_x,
  input  wire logic signed [gmd_pkg::COORD_W-1:0] key_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    accepted,
  output logic [gmd_pkg::ID_W-1:0]                feature_id,
  input  wire logic                               cfg_write,
  input  wire logic [gmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gmd_pkg::DIM_W-1:0]          cfg_data
);

  logic [gmd_pkg::DIM_W-1:0]   image_width;
  logic [gmd_pkg::DIM_W-1:0]   image_height;
  logic [gmd_pkg::CELL_W-1:0]  cell_pixels;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  gmd_pkg::entry_t             q_din;
  gmd_pkg::entry_t             q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gmd_pkg::WIDTH_RESET;
      image_height <= gmd_pkg::HEIGHT_RESET;
      cell_pixels  <= gmd_pkg::CELL_RESET;
    end else if (cfg_write) begin
      case (gmd_pkg::cfg_reg_t'(cfg_index))
        gmd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        gmd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        gmd_pkg::REG_CELL_PIXELS:  cell_pixels  <= cfg_data[gmd_pkg::CELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .key_x        (key_x),
    .key_y        (key_y),
    .image_width  (image_width),
    .image_height (image_height),
    .cell_pixels  (cell_pixels),
    .push         (q_push),
    .entry        (q_din),
    .full         (q_full)
  );

  gmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  gmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accepted   (accepted),
    .feature_id (feature_id)
  );

endmodule
`default_nettype wire
